// ===== hdl/sdspi_pkg.sv =====
// package for the sd card spi sequencer: phase codes, command codes, field types
// no dependencies
package sdspi_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int CNT_W = $clog2(SECTOR_BYTES) + 1;
    localparam int OFF_W = 9;

    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_BYTE = 2'd2;

    localparam logic [0:0] CFG_POLL_BUDGET = 1'd0;
    localparam logic [0:0] CFG_IDLE_CLOCKS = 1'd1;

    localparam logic [7:0] C_CMD0   = 8'h40;
    localparam logic [7:0] C_CMD1   = 8'h41;
    localparam logic [7:0] C_CMD8   = 8'h48;
    localparam logic [7:0] C_CMD17  = 8'h51;
    localparam logic [7:0] C_CMD55  = 8'h77;
    localparam logic [7:0] C_CMD58  = 8'h7A;
    localparam logic [7:0] C_ACMD41 = 8'h69;

    typedef enum logic [4:0] {
        PH_IDLE, PH_CLK, PH_FRAME, PH_FRAMEL, PH_CMD0_R, PH_CMD8_R, PH_R7,
        PH_CMD58_R, PH_OCR, PH_CMD55_R, PH_ACMD41_R, PH_CMD1_R, PH_END_A,
        PH_END_B, PH_RD_PRE, PH_RD_PRE2, PH_CMD17_R, PH_TOKEN, PH_DATA, PH_TRAIL
    } phase_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] sector_number;
        logic [9:0]  window_start;
        logic [9:0]  window_end;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        select_high;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [8:0]  data_offset;
        logic        done_res;
    } out_item_t;

    function automatic logic [7:0] crc_of(input logic [7:0] idx);
        logic [7:0] c;
        case (idx)
            C_CMD0:   c = 8'h95;
            C_CMD8:   c = 8'h87;
            C_CMD58:  c = 8'hFD;
            C_CMD55:  c = 8'h65;
            C_ACMD41: c = 8'h77;
            default:  c = 8'h01;
        endcase
        return c;
    endfunction

    function automatic phase_t resp_phase(input logic [7:0] idx);
        phase_t p;
        case (idx)
            C_CMD0:   p = PH_CMD0_R;
            C_CMD8:   p = PH_CMD8_R;
            C_CMD58:  p = PH_CMD58_R;
            C_CMD55:  p = PH_CMD55_R;
            C_ACMD41: p = PH_ACMD41_R;
            C_CMD1:   p = PH_CMD1_R;
            default:  p = PH_CMD17_R;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/sdspi_in_if.sv =====
// valid/ready channel carrying input items
// depends on sdspi_pkg
interface sdspi_in_if import sdspi_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sdspi_out_if.sv =====
// valid/ready channel carrying result items
// depends on sdspi_pkg
interface sdspi_out_if import sdspi_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sd_spi_init_and_sector_read.sv =====
// An accepted item's result is registered in the output register, or held in
// the one-entry skid stage when the output stalls. Throughput: one item per
// cycle while the skid stage is empty; the sequencer state updates in the
// accept cycle, and a result waiting in the output register does not block the next item.
// Reset: phase idle, counters zero, chip select high, poll_budget 50, idle clocks 12.
// depends on sdspi_pkg, sdspi_in_if, sdspi_out_if
module sd_spi_init_and_sector_read
    import sdspi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    sdspi_in_if.sink    in_ch,
    sdspi_out_if.source out_ch
);

    logic [7:0]       poll_budget_reg, idle_clocks_reg;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [31:0]      arg_reg, arg_next;
    logic [7:0]       poll_reg, poll_next;
    logic [9:0]       first_reg, first_next, after_reg, after_next;
    logic             sel_reg, sel_next;

    out_item_t res;
    out_item_t out_reg, skid_reg;
    logic      out_valid_reg, skid_valid_reg;
    logic      accept;

    assign in_ch.ready  = !skid_valid_reg;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_budget_reg <= 8'd50;
            idle_clocks_reg <= 8'd12;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLL_BUDGET: poll_budget_reg <= cfg_data;
                CFG_IDLE_CLOCKS: idle_clocks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state and result for one item
    always_comb
    begin
        logic [7:0]       rx;
        logic [CNT_W-1:0] cnt_inc;
        logic             respond;
        logic [7:0]       p_dec;
        rx         = in_ch.data.rx_byte;
        cnt_inc    = count_reg + 1'b1;
        respond    = 1'b0;
        p_dec      = poll_reg - 8'd1;
        phase_next = phase_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        arg_next   = arg_reg;
        poll_next  = poll_reg;
        first_next = first_reg;
        after_next = after_reg;
        sel_next   = sel_reg;
        res        = '0;

        case (in_ch.data.operation)
            OP_INIT:
            begin
                sel_next = 1'b1;
                res.tx_valid = 1'b1;
                count_next = '0;
                if (idle_clocks_reg != 8'd0)
                begin
                    phase_next = PH_CLK;
                    res.tx_byte = 8'hFF;
                end
                else
                begin
                    sel_next = 1'b0;
                    cmd_next = C_CMD0;
                    arg_next = '0;
                    phase_next = PH_FRAME;
                    res.tx_byte = C_CMD0;
                end
            end
            OP_READ:
            begin
                first_next = in_ch.data.window_start;
                after_next = in_ch.data.window_end;
                arg_next = in_ch.data.sector_number;
                phase_next = PH_RD_PRE;
                res.tx_valid = 1'b1;
                res.tx_byte = 8'hFF;
            end
            OP_BYTE:
            begin
                case (phase_reg)
                    PH_CLK:
                    begin
                        count_next = cnt_inc;
                        res.tx_valid = 1'b1;
                        res.tx_byte = 8'hFF;
                        if (cnt_inc >= CNT_W'(idle_clocks_reg))
                        begin
                            sel_next = 1'b0;
                            cmd_next = C_CMD0;
                            arg_next = '0;
                            count_next = '0;
                            phase_next = PH_FRAME;
                            res.tx_byte = C_CMD0;
                        end
                    end
                    PH_FRAME, PH_FRAMEL:
                    begin
                        if (count_reg < CNT_W'(5))
                        begin
                            count_next = cnt_inc;
                            res.tx_valid = 1'b1;
                            case (cnt_inc[2:0])
                                3'd1: res.tx_byte = arg_reg[31:24];
                                3'd2: res.tx_byte = arg_reg[23:16];
                                3'd3: res.tx_byte = arg_reg[15:8];
                                3'd4: res.tx_byte = arg_reg[7:0];
                                default: res.tx_byte = crc_of(cmd_reg);
                            endcase
                        end
                        else if (phase_reg == PH_FRAMEL)
                        begin
                            phase_next = PH_ACMD41_R;
                            res.tx_valid = 1'b1;
                            res.tx_byte = 8'hFF;
                        end
                        else
                            respond = 1'b1;
                    end
                    PH_R7, PH_OCR:
                    begin
                        count_next = cnt_inc;
                        res.tx_valid = 1'b1;
                        res.tx_byte = 8'hFF;
                        if (cnt_inc >= CNT_W'(4))
                        begin
                            cmd_next = (phase_reg == PH_R7) ? C_CMD58 : C_CMD55;
                            arg_next = '0;
                            count_next = '0;
                            phase_next = PH_FRAME;
                            res.tx_byte = cmd_next;
                        end
                    end
                    PH_CMD0_R, PH_CMD8_R, PH_CMD58_R, PH_CMD55_R,
                    PH_ACMD41_R, PH_CMD1_R, PH_CMD17_R, PH_TOKEN:
                        respond = 1'b1;
                    PH_END_A:
                    begin
                        sel_next = 1'b1;
                        phase_next = PH_END_B;
                        res.tx_valid = 1'b1;
                        res.tx_byte = 8'hFF;
                    end
                    PH_END_B:
                    begin
                        sel_next = 1'b1;
                        phase_next = PH_IDLE;
                        res.done_res = 1'b1;
                    end
                    PH_RD_PRE:
                    begin
                        sel_next = 1'b0;
                        phase_next = PH_RD_PRE2;
                        res.tx_valid = 1'b1;
                        res.tx_byte = 8'hFF;
                    end
                    PH_RD_PRE2:
                    begin
                        cmd_next = C_CMD17;
                        count_next = '0;
                        phase_next = PH_FRAME;
                        res.tx_valid = 1'b1;
                        res.tx_byte = C_CMD17;
                    end
                    PH_DATA:
                    begin
                        if (10'(count_reg) >= first_reg && 10'(count_reg) < after_reg)
                        begin
                            res.data_valid = 1'b1;
                            res.data_byte = rx;
                            res.data_offset = count_reg[OFF_W-1:0];
                        end
                        count_next = cnt_inc;
                        if (cnt_inc >= CNT_W'(SECTOR_BYTES))
                        begin
                            count_next = '0;
                            phase_next = PH_TRAIL;
                        end
                        res.tx_valid = 1'b1;
                        res.tx_byte = 8'hFF;
                    end
                    PH_TRAIL:
                    begin
                        count_next = cnt_inc;
                        if (cnt_inc >= CNT_W'(3))
                        begin
                            sel_next = 1'b1;
                            phase_next = PH_END_B;
                        end
                        res.tx_valid = 1'b1;
                        res.tx_byte = 8'hFF;
                    end
                    default: ;
                endcase

                // response handling, with the phase a finished frame resolves to
                if (respond)
                begin
                    phase_t ph;
                    ph = (phase_reg == PH_FRAME) ? resp_phase(cmd_reg) : phase_reg;
                    phase_next = ph;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                    case (ph)
                        PH_CMD0_R:
                            if (rx == 8'h01)
                            begin
                                cmd_next = C_CMD8; arg_next = 32'h1AA;
                            end
                        PH_CMD8_R:
                            if (rx == 8'h01)
                            begin
                                count_next = '0; phase_next = PH_R7;
                            end
                            else if (rx == 8'h05 || rx == 8'h0D)
                            begin
                                cmd_next = C_CMD58; arg_next = '0;
                            end
                        PH_CMD58_R:
                            if (rx == 8'h01)
                            begin
                                count_next = '0; phase_next = PH_OCR;
                            end
                        PH_CMD55_R:
                            if (rx == 8'h01 || rx == 8'h00)
                            begin
                                poll_next = poll_budget_reg;
                                cmd_next = C_ACMD41; arg_next = 32'h4000_0000;
                            end
                        PH_ACMD41_R:
                            if (rx == 8'h00 || poll_reg == 8'd0)
                            begin
                                cmd_next = C_CMD1; arg_next = 32'h4000_0000;
                            end
                            else
                            begin
                                poll_next = p_dec;
                                if (rx == 8'h01)
                                begin
                                    cmd_next = C_CMD55; arg_next = '0;
                                end
                                else if (p_dec == 8'd1)
                                begin
                                    poll_next = poll_budget_reg;
                                    cmd_next = C_CMD1; arg_next = 32'h4000_0000;
                                    count_next = '0;
                                    phase_next = PH_FRAMEL;
                                    res.tx_byte = C_CMD1;
                                end
                            end
                        PH_CMD1_R:
                            if (rx == 8'h00)
                                phase_next = PH_END_A;
                            else if (rx == 8'h01)
                            begin
                                cmd_next = C_CMD55; arg_next = '0;
                            end
                        PH_CMD17_R:
                            if (rx == 8'h00)
                                phase_next = PH_TOKEN;
                        default:
                            if (rx == 8'hFE)
                            begin
                                count_next = '0; phase_next = PH_DATA;
                            end
                    endcase
                    // a new command frame starts whenever the command changed
                    if (phase_next == ph && cmd_next != cmd_reg ||
                        phase_next == ph && arg_next != arg_reg ||
                        phase_next == ph && poll_next == poll_budget_reg &&
                        ph == PH_CMD55_R && (rx == 8'h01 || rx == 8'h00) ||
                        phase_next == ph && ph == PH_ACMD41_R &&
                        (rx == 8'h00 || poll_reg == 8'd0 || rx == 8'h01) ||
                        phase_next == ph && ph == PH_CMD1_R && rx == 8'h01 ||
                        phase_next == ph && ph == PH_CMD0_R && rx == 8'h01 ||
                        phase_next == ph && ph == PH_CMD8_R &&
                        (rx == 8'h05 || rx == 8'h0D))
                    begin
                        count_next = '0;
                        phase_next = PH_FRAME;
                        res.tx_byte = cmd_next;
                    end
                end
            end
            default: ;
        endcase
        res.select_high = sel_next;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            cmd_reg   <= '0;
            arg_reg   <= '0;
            poll_reg  <= '0;
            first_reg <= '0;
            after_reg <= '0;
            sel_reg   <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            cmd_reg   <= cmd_next;
            arg_reg   <= arg_next;
            poll_reg  <= poll_next;
            first_reg <= first_next;
            after_reg <= after_next;
            sel_reg   <= sel_next;
        end
    end

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ch.ready)
            begin
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ch.ready)
            out_reg <= skid_valid_reg ? skid_reg : res;
        if (accept && out_valid_reg && !out_ch.ready)
            skid_reg <= res;
    end

    // checks
    a_skid_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg) else $error("skid holds item with empty output");
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.done_res |=> phase_reg == PH_IDLE) else $error("done without idle");
    a_data_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.data_valid |-> phase_reg == PH_DATA) else $error("stray data byte");
    a_deselect_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.done_res |-> res.select_high && !res.tx_valid)
        else $error("done with select low");

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the sd card spi sequencer: init and sector read sequences
// driven against an in-bench model of the sequencer and a simple card responder
// depends on sdspi_pkg, sdspi_in_if, sdspi_out_if, sd_spi_init_and_sector_read
module tb;
    import sdspi_pkg::*;

    localparam int HALF = 10;
    localparam int LIMIT_CYCLES = 400000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    sdspi_in_if  in_ch ();
    sdspi_out_if out_ch ();

    sd_spi_init_and_sector_read DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source)
    );

    // sequencer model state
    phase_t     seq_phase;
    logic [9:0] seq_count;
    logic [7:0] cmd_idx;
    logic [31:0] cmd_arg;
    logic [7:0] polls_left;
    logic [9:0] win_lo;
    logic [9:0] win_hi;
    logic       cs_high;
    logic [7:0] poll_budget;
    logic [7:0] idle_clks;
    out_item_t  step_res;

    out_item_t  expected_results[$];
    int         errors;
    int         items_sent;
    logic       quiet;
    logic       hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #HALF clk = ~clk;
    end

    // run limit
    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------- sequencer model ----------------

    task automatic put_tx(input logic [7:0] b);
        step_res.tx_valid = 1'b1;
        step_res.tx_byte  = b;
    endtask

    task automatic frame_start(input logic [7:0] idx, input logic [31:0] arg, input phase_t p);
        cmd_idx   = idx;
        cmd_arg   = arg;
        seq_count = '0;
        seq_phase = p;
        put_tx(idx);
    endtask

    function automatic logic [7:0] cmd_crc(input logic [7:0] idx);
        case (idx)
            C_CMD0:   return 8'h95;
            C_CMD8:   return 8'h87;
            C_CMD58:  return 8'hFD;
            C_CMD55:  return 8'h65;
            C_ACMD41: return 8'h77;
            default:  return 8'h01;
        endcase
    endfunction

    function automatic logic [7:0] frame_byte(input logic [9:0] k);
        case (k)
            10'd0:   return cmd_idx;
            10'd1:   return cmd_arg[31:24];
            10'd2:   return cmd_arg[23:16];
            10'd3:   return cmd_arg[15:8];
            10'd4:   return cmd_arg[7:0];
            default: return cmd_crc(cmd_idx);
        endcase
    endfunction

    function automatic phase_t wait_phase(input logic [7:0] idx);
        case (idx)
            C_CMD0:   return PH_CMD0_R;
            C_CMD8:   return PH_CMD8_R;
            C_CMD58:  return PH_CMD58_R;
            C_CMD55:  return PH_CMD55_R;
            C_ACMD41: return PH_ACMD41_R;
            C_CMD1:   return PH_CMD1_R;
            default:  return PH_CMD17_R;
        endcase
    endfunction

    // handle one card response byte in the current wait phase
    task automatic take_response(input logic [7:0] r);
        case (seq_phase)
            PH_CMD0_R:
                if (r == 8'h01) frame_start(C_CMD8, 32'h1AA, PH_FRAME);
                else put_tx(8'hFF);
            PH_CMD8_R:
                if (r == 8'h01)
                begin
                    seq_count = '0;
                    seq_phase = PH_R7;
                    put_tx(8'hFF);
                end
                else if (r == 8'h05 || r == 8'h0D) frame_start(C_CMD58, 32'h0, PH_FRAME);
                else put_tx(8'hFF);
            PH_CMD58_R:
            begin
                if (r == 8'h01)
                begin
                    seq_count = '0;
                    seq_phase = PH_OCR;
                end
                put_tx(8'hFF);
            end
            PH_CMD55_R:
                if (r == 8'h01 || r == 8'h00)
                begin
                    polls_left = poll_budget;
                    frame_start(C_ACMD41, 32'h4000_0000, PH_FRAME);
                end
                else put_tx(8'hFF);
            PH_ACMD41_R:
                if (r == 8'h00 || polls_left == 8'd0)
                    frame_start(C_CMD1, 32'h4000_0000, PH_FRAME);
                else
                begin
                    polls_left = polls_left - 8'd1;
                    if (r == 8'h01) frame_start(C_CMD55, 32'h0, PH_FRAME);
                    else if (polls_left == 8'd1)
                    begin
                        polls_left = poll_budget;
                        frame_start(C_CMD1, 32'h4000_0000, PH_FRAMEL);
                    end
                    else put_tx(8'hFF);
                end
            PH_CMD1_R:
                if (r == 8'h00)
                begin
                    seq_phase = PH_END_A;
                    put_tx(8'hFF);
                end
                else if (r == 8'h01) frame_start(C_CMD55, 32'h0, PH_FRAME);
                else put_tx(8'hFF);
            PH_CMD17_R:
            begin
                if (r == 8'h00) seq_phase = PH_TOKEN;
                put_tx(8'hFF);
            end
            default:
            begin
                if (r == 8'hFE)
                begin
                    seq_count = '0;
                    seq_phase = PH_DATA;
                end
                put_tx(8'hFF);
            end
        endcase
    endtask

    // advance the model by one accepted item and queue its result
    task automatic predict_result(input in_item_t it);
        step_res = '0;
        case (it.operation)
            OP_INIT:
            begin
                cs_high = 1'b1;
                if (idle_clks != 8'd0)
                begin
                    seq_count = '0;
                    seq_phase = PH_CLK;
                    put_tx(8'hFF);
                end
                else
                begin
                    cs_high = 1'b0;
                    frame_start(C_CMD0, 32'h0, PH_FRAME);
                end
            end
            OP_READ:
            begin
                win_lo    = it.window_start;
                win_hi    = it.window_end;
                cmd_arg   = it.sector_number;
                seq_phase = PH_RD_PRE;
                put_tx(8'hFF);
            end
            OP_BYTE:
                case (seq_phase)
                    PH_CLK:
                    begin
                        seq_count = seq_count + 10'd1;
                        if (seq_count < {2'b00, idle_clks}) put_tx(8'hFF);
                        else
                        begin
                            cs_high = 1'b0;
                            frame_start(C_CMD0, 32'h0, PH_FRAME);
                        end
                    end
                    PH_FRAME, PH_FRAMEL:
                        if (seq_count < 10'd5)
                        begin
                            seq_count = seq_count + 10'd1;
                            put_tx(frame_byte(seq_count));
                        end
                        else if (seq_phase == PH_FRAMEL)
                        begin
                            seq_phase = PH_ACMD41_R;
                            put_tx(8'hFF);
                        end
                        else
                        begin
                            seq_phase = wait_phase(cmd_idx);
                            take_response(it.rx_byte);
                        end
                    PH_R7, PH_OCR:
                    begin
                        seq_count = seq_count + 10'd1;
                        if (seq_count < 10'd4) put_tx(8'hFF);
                        else if (seq_phase == PH_R7) frame_start(C_CMD58, 32'h0, PH_FRAME);
                        else frame_start(C_CMD55, 32'h0, PH_FRAME);
                    end
                    PH_CMD0_R, PH_CMD8_R, PH_CMD58_R, PH_CMD55_R,
                    PH_ACMD41_R, PH_CMD1_R, PH_CMD17_R, PH_TOKEN:
                        take_response(it.rx_byte);
                    PH_END_A:
                    begin
                        cs_high   = 1'b1;
                        seq_phase = PH_END_B;
                        put_tx(8'hFF);
                    end
                    PH_END_B:
                    begin
                        cs_high   = 1'b1;
                        seq_phase = PH_IDLE;
                        step_res.done_res = 1'b1;
                    end
                    PH_RD_PRE:
                    begin
                        cs_high   = 1'b0;
                        seq_phase = PH_RD_PRE2;
                        put_tx(8'hFF);
                    end
                    PH_RD_PRE2:
                        frame_start(C_CMD17, cmd_arg, PH_FRAME);
                    PH_DATA:
                    begin
                        if (seq_count >= win_lo && seq_count < win_hi)
                        begin
                            step_res.data_valid  = 1'b1;
                            step_res.data_byte   = it.rx_byte;
                            step_res.data_offset = seq_count[8:0];
                        end
                        seq_count = seq_count + 10'd1;
                        if (seq_count >= SECTOR_BYTES)
                        begin
                            seq_count = '0;
                            seq_phase = PH_TRAIL;
                        end
                        put_tx(8'hFF);
                    end
                    PH_TRAIL:
                    begin
                        seq_count = seq_count + 10'd1;
                        if (seq_count >= 10'd3)
                        begin
                            cs_high   = 1'b1;
                            seq_phase = PH_END_B;
                        end
                        put_tx(8'hFF);
                    end
                    default: ;
                endcase
            default: ;
        endcase
        step_res.select_high = cs_high;
        expected_results.push_back(step_res);
    endtask

    // ---------------- driving ----------------

    task automatic send_item(input logic [1:0] op, input logic [31:0] sector,
                             input logic [9:0] lo, input logic [9:0] hi,
                             input logic [7:0] rx);
        in_item_t it;
        it.operation     = op;
        it.sector_number = sector;
        it.window_start  = lo;
        it.window_end    = hi;
        it.rx_byte       = rx;
        // random sender gaps
        if (!quiet && $urandom_range(99) < 9)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict_result(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    // registers are written with the block drained
    task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
        go_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_POLL_BUDGET) poll_budget = val;
        else idle_clks = val;
    endtask

    // card side: mostly the answer that moves the sequence on
    function automatic logic [7:0] card_reply();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return 8'($urandom);
        case (seq_phase)
            PH_CMD0_R:   return 8'h01;
            PH_CMD8_R:   return (roll < 60) ? 8'h01 : ((roll < 80) ? 8'h05 : 8'h0D);
            PH_CMD58_R:  return 8'h01;
            PH_CMD55_R:  return (roll < 70) ? 8'h01 : 8'h00;
            PH_ACMD41_R: return (roll < 55) ? 8'h01 : ((roll < 80) ? 8'h00 : 8'hFF);
            PH_CMD1_R:   return (roll < 70) ? 8'h00 : 8'h01;
            PH_CMD17_R:  return (roll < 60) ? 8'h00 : 8'hFF;
            PH_TOKEN:    return (roll < 50) ? 8'hFE : 8'hFF;
            default:     return 8'($urandom);
        endcase
    endfunction

    // feed card bytes until the sequence completes
    task automatic run_to_done();
        while (seq_phase != PH_IDLE)
            send_item(OP_BYTE, 32'($urandom), 10'($urandom), 10'($urandom), card_reply());
    endtask

    task automatic start_read(input logic [9:0] lo, input logic [9:0] hi);
        send_item(OP_READ, $urandom, lo, hi, 8'($urandom));
    endtask

    // ---------------- result checking ----------------

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t exp_r;
        out_item_t got_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got_r = out_ch.data;
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected item, actual %0h", $time, got_r);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("tx_valid", exp_r.tx_valid, got_r.tx_valid);
                check_field("tx_byte", exp_r.tx_byte, got_r.tx_byte);
                check_field("select_high", exp_r.select_high, got_r.select_high);
                check_field("data_valid", exp_r.data_valid, got_r.data_valid);
                check_field("data_byte", exp_r.data_byte, got_r.data_byte);
                check_field("data_offset", exp_r.data_offset, got_r.data_offset);
                check_field("done_res", exp_r.done_res, got_r.done_res);
            end
        end
    end

    // result side ready, with random stalls and a long hold on request
    initial
    begin
        int hold_cycles;
        hold_cycles = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_cycles = 300;
                hold_req = 1'b0;
            end
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (quiet) out_ch.ready <= 1'b1;
            else out_ch.ready <= ($urandom_range(99) >= 9);
        end
    end

    // ---------------- tests ----------------

    // ignored and odd items while idle, aborts, zero idle clocks
    task automatic test_idle_and_abort();
        send_item(OP_BYTE, 32'h0, 10'h0, 10'h0, 8'h00);
        send_item(OP_BYTE, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF, 8'hFF);
        send_item(2'd3, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF, 8'hFF);
        start_read(10'd512, 10'd0);
        send_item(OP_BYTE, 32'h0, 10'h0, 10'h0, 8'h00);
        send_item(OP_INIT, 32'h0, 10'h0, 10'h0, 8'h00);
        send_item(OP_BYTE, 32'h0, 10'h0, 10'h0, 8'hFF);
        send_item(2'd3, 32'h0, 10'h0, 10'h0, 8'h55);
        send_item(OP_READ, 32'hFFFF_FFFF, 10'd0, 10'd512, 8'hAA);
        repeat (8) send_item(OP_BYTE, 32'h0, 10'h0, 10'h0, 8'hFF);
        write_reg(CFG_IDLE_CLOCKS, 8'd0);
        send_item(OP_INIT, 32'h0, 10'h0, 10'h0, 8'h00);
        repeat (6) send_item(OP_BYTE, 32'h0, 10'h0, 10'h0, 8'h01);
        send_item(OP_INIT, 32'h0, 10'h0, 10'h0, 8'h00);
        run_to_done();
    endtask

    // full init runs across register settings, budget extremes included
    task automatic test_init_runs();
        write_reg(CFG_IDLE_CLOCKS, 8'd1);
        write_reg(CFG_POLL_BUDGET, 8'd2);
        send_item(OP_INIT, 32'h0, 10'h0, 10'h0, 8'h00);
        run_to_done();
        write_reg(CFG_POLL_BUDGET, 8'd0);
        send_item(OP_INIT, 32'h0, 10'h0, 10'h0, 8'h00);
        run_to_done();
        write_reg(CFG_POLL_BUDGET, 8'd1);
        write_reg(CFG_IDLE_CLOCKS, 8'd255);
        send_item(OP_INIT, 32'h0, 10'h0, 10'h0, 8'h00);
        run_to_done();
        write_reg(CFG_POLL_BUDGET, 8'd255);
        write_reg(CFG_IDLE_CLOCKS, 8'd12);
        send_item(OP_INIT, 32'h0, 10'h0, 10'h0, 8'h00);
        run_to_done();
    endtask

    // a sector read with the output held off long enough to back up the input
    task automatic test_backpressure();
        quiet = 1'b1;
        start_read(10'd0, 10'd512);
        hold_req = 1'b1;
        repeat (40) send_item(OP_BYTE, 32'h0, 10'h0, 10'h0, card_reply());
        run_to_done();
        quiet = 1'b0;
    endtask

    // random sequences: mostly well formed, some aborts and noise
    task automatic test_random(input int target);
        int roll;
        logic [9:0] lo;
        logic [9:0] hi;
        while (items_sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 5)
                write_reg(CFG_POLL_BUDGET, 8'($urandom_range(255, 2)));
            else if (roll < 8)
                write_reg(CFG_IDLE_CLOCKS, 8'($urandom_range(20)));
            roll = $urandom_range(99);
            if (roll < 45)
                send_item(OP_INIT, $urandom, 10'($urandom), 10'($urandom), 8'($urandom));
            else
            begin
                lo = 10'($urandom_range(512));
                hi = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(512));
                start_read(lo, hi);
            end
            while (seq_phase != PH_IDLE)
            begin
                roll = $urandom_range(999);
                if (roll < 3)
                    send_item(OP_INIT, $urandom, 10'($urandom), 10'($urandom), 8'($urandom));
                else if (roll < 5)
                    send_item(2'd3, $urandom, 10'($urandom), 10'($urandom), 8'($urandom));
                else
                    send_item(OP_BYTE, $urandom, 10'($urandom), 10'($urandom), card_reply());
            end
        end
    endtask

    // main sequence
    initial
    begin
        errors     = 0;
        items_sent = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_POLL_BUDGET;
        cfg_data   = 8'd0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        seq_phase  = PH_IDLE;
        seq_count  = '0;
        cmd_idx    = '0;
        cmd_arg    = '0;
        polls_left = '0;
        win_lo     = '0;
        win_hi     = '0;
        cs_high    = 1'b1;
        poll_budget = 8'd50;
        idle_clks  = 8'd12;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_and_abort();
        test_init_runs();
        test_backpressure();
        test_random(1100);

        go_idle();
        repeat (10) @(negedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sdspi_pkg.sv
hdl/sdspi_in_if.sv
hdl/sdspi_out_if.sv
hdl/sd_spi_init_and_sector_read.sv
bench/tb.sv
